FILE: sv/mtt_pkg.sv
// Shared types and constants for the movetext tokenizer.
`timescale 1ns / 1ps
package mtt_pkg;

  localparam int TokenCap = 15;
  localparam int TokLenW  = 4;
  localparam int DepthW   = 8;

  localparam logic [DepthW-1:0] DepthMax = '1;

  typedef enum logic [2:0] {
    ModeNormal = 3'b001,
    ModeBrace  = 3'b010,
    ModeParen  = 3'b100
  } mode_e;

  typedef enum logic [1:0] {
    KindMove    = 2'd0,
    KindGameEnd = 2'd1,
    KindEnd     = 2'd2
  } kind_e;

  localparam logic [1:0] ResUnknown = 2'd0;
  localparam logic [1:0] ResWhite   = 2'd1;
  localparam logic [1:0] ResBlack   = 2'd2;
  localparam logic [1:0] ResDraw    = 2'd3;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLBrace = 8'h7b;
  localparam logic [7:0] ChRBrace = 8'h7d;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChOne    = 8'h31;
  localparam logic [7:0] ChTwo    = 8'h32;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChDash   = 8'h2d;
  localparam logic [7:0] ChSlash  = 8'h2f;

endpackage

FILE: sv/movetext_tokenizer_unit.sv
// Movetext tokenizer: splits game-record movetext into move characters and result items.
`timescale 1ns / 1ps
// One movetext byte is taken per beat, and a byte that finishes no token is taken every
// cycle while no earlier token is being sent. A delimiter or an end-of-stream beat that
// finishes a token hands the token to an emit register, which sends one result beat per
// cycle through the output register while the receiver takes them; the input stays
// stalled until the last of those beats has moved to the output register, so such a
// byte holds the input while its result items (up to 16) are sent, and longer while
// the receiver holds off. Tokens longer than 15 characters keep their first 15. The
// end-of-stream beat also returns all scanning state to its reset values.
module movetext_tokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tuser_i,   // [0] end_of_stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] move_char, [9:8] game_result, [15:10] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] item_kind
  output logic        m_axis_tlast_o    // last_of_run
);
  import mtt_pkg::*;

  mode_e               mode_q, mode_d;
  logic [DepthW-1:0]   depth_q, depth_d, depth_dec;
  logic [TokLenW-1:0]  tok_len_q, tok_len_d;
  logic [7:0]          tok_chars_q [TokenCap];
  logic                tok_wr;

  logic [7:0]          job_chars_q [TokenCap];
  logic [TokLenW-1:0]  job_len_q, job_len_d;
  logic [TokLenW-1:0]  job_pos_q, job_pos_d;
  logic                job_gend_q, job_gend_d;
  logic [1:0]          job_res_q, job_res_d;
  logic                job_eos_q, job_eos_d;
  logic                job_busy, job_load;

  logic                m_valid_q, m_valid_d;
  kind_e               m_kind_q, m_kind_d;
  logic [7:0]          m_char_q, m_char_d;
  logic [1:0]          m_res_q, m_res_d;
  logic                m_last_q, m_last_d;

  logic                in_acc, out_free, emit;
  logic [7:0]          byte_in;
  logic                is_delim, tok_any, is_star, is_white, is_black, is_draw;
  logic                is_result, is_drop;
  logic [1:0]          res_code;

  assign byte_in  = s_axis_tdata_i;
  assign job_busy = job_gend_q || (job_pos_q != job_len_q) || job_eos_q;
  assign s_axis_tready_o = !job_busy;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign emit     = job_busy && out_free;

  assign is_delim = (byte_in == ChSpace) || (byte_in == ChDot) || (byte_in == ChLf) ||
                    (byte_in == ChCr) || (byte_in == ChTab);
  assign depth_dec = (depth_q != '0) ? depth_q - 1'b1 : '0;

  assign tok_any  = (tok_len_q != '0);
  assign is_star  = (tok_len_q == TokLenW'(1)) && (tok_chars_q[0] == ChStar);
  assign is_white = (tok_len_q == TokLenW'(3)) && (tok_chars_q[0] == ChOne) &&
                    (tok_chars_q[1] == ChDash) && (tok_chars_q[2] == ChZero);
  assign is_black = (tok_len_q == TokLenW'(3)) && (tok_chars_q[0] == ChZero) &&
                    (tok_chars_q[1] == ChDash) && (tok_chars_q[2] == ChOne);
  assign is_draw  = (tok_len_q == TokLenW'(7)) && (tok_chars_q[0] == ChOne) &&
                    (tok_chars_q[1] == ChSlash) && (tok_chars_q[2] == ChTwo) &&
                    (tok_chars_q[3] == ChDash) && (tok_chars_q[4] == ChOne) &&
                    (tok_chars_q[5] == ChSlash) && (tok_chars_q[6] == ChTwo);
  assign is_result = is_star || is_white || is_black || is_draw;
  assign is_drop   = ((tok_chars_q[0] >= ChZero) && (tok_chars_q[0] <= ChNine)) ||
                     (tok_chars_q[0] == ChDollar);
  assign res_code  = is_white ? ResWhite : is_black ? ResBlack : is_draw ? ResDraw : ResUnknown;

  always_comb begin
    mode_d    = mode_q;
    depth_d   = depth_q;
    tok_len_d = tok_len_q;
    tok_wr    = 1'b0;
    job_load  = 1'b0;
    if (in_acc) begin
      if (s_axis_tuser_i) begin
        job_load  = 1'b1;
        mode_d    = ModeNormal;
        depth_d   = '0;
        tok_len_d = '0;
      end else begin
        unique case (mode_q)
          ModeBrace: begin
            if (byte_in == ChRBrace) mode_d = ModeNormal;
          end
          ModeParen: begin
            if (byte_in == ChRParen) begin
              depth_d = depth_dec;
              if (depth_dec == '0) mode_d = ModeNormal;
            end else if (byte_in == ChLParen && depth_q != DepthMax) begin
              depth_d = depth_q + 1'b1;
            end
          end
          ModeNormal: begin
            if (!tok_any && byte_in == ChLBrace) begin
              mode_d = ModeBrace;
            end else if (!tok_any && byte_in == ChLParen) begin
              mode_d  = ModeParen;
              depth_d = DepthW'(1);
            end else if (is_delim) begin
              job_load  = 1'b1;
              tok_len_d = '0;
            end else if (tok_len_q < TokLenW'(TokenCap)) begin
              tok_wr    = 1'b1;
              tok_len_d = tok_len_q + 1'b1;
            end
          end
          default: mode_d = ModeNormal;
        endcase
      end
    end
  end

  always_comb begin
    job_len_d  = job_len_q;
    job_pos_d  = job_pos_q;
    job_gend_d = job_gend_q;
    job_res_d  = job_res_q;
    job_eos_d  = job_eos_q;
    m_valid_d  = m_valid_q;
    m_kind_d   = m_kind_q;
    m_char_d   = m_char_q;
    m_res_d    = m_res_q;
    m_last_d   = m_last_q;
    if (out_free) m_valid_d = 1'b0;
    if (job_load) begin
      job_gend_d = tok_any && is_result;
      job_res_d  = res_code;
      job_len_d  = (tok_any && !is_result && !is_drop) ? tok_len_q : '0;
      job_pos_d  = '0;
      job_eos_d  = s_axis_tuser_i;
    end else if (emit) begin
      m_valid_d = 1'b1;
      m_char_d  = '0;
      m_res_d   = ResUnknown;
      if (job_gend_q) begin
        m_kind_d   = KindGameEnd;
        m_res_d    = job_res_q;
        m_last_d   = !job_eos_q;
        job_gend_d = 1'b0;
      end else if (job_pos_q != job_len_q) begin
        m_kind_d  = KindMove;
        m_char_d  = job_chars_q[job_pos_q];
        m_last_d  = (job_pos_q + 1'b1 == job_len_q) && !job_eos_q;
        job_pos_d = job_pos_q + 1'b1;
      end else begin
        m_kind_d  = KindEnd;
        m_last_d  = 1'b1;
        job_eos_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeNormal;
      depth_q    <= '0;
      tok_len_q  <= '0;
      job_len_q  <= '0;
      job_pos_q  <= '0;
      job_gend_q <= 1'b0;
      job_eos_q  <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      depth_q    <= depth_d;
      tok_len_q  <= tok_len_d;
      job_len_q  <= job_len_d;
      job_pos_q  <= job_pos_d;
      job_gend_q <= job_gend_d;
      job_eos_q  <= job_eos_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_wr) tok_chars_q[tok_len_q] <= byte_in;
    if (job_load) job_chars_q <= tok_chars_q;
    job_res_q <= job_res_d;
    m_kind_q  <= m_kind_d;
    m_char_q  <= m_char_d;
    m_res_q   <= m_res_d;
    m_last_q  <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {6'b0, m_res_q, m_char_q};
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;

`ifndef SYNTHESIS
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_kind_q == KindEnd) |-> m_last_q)
    else $error("end marker without last mark");

  a_mode_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != ModeNormal) |-> (tok_len_q == '0))
    else $error("token pending inside comment or variation");

  a_paren_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeParen) |-> (depth_q != '0))
    else $error("variation mode with zero depth");

  a_eos_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i) |=> (mode_q == ModeNormal && tok_len_q == '0 &&
                                   depth_q == '0 && job_eos_q))
    else $error("end of stream did not restore scan state");

  a_nonmove_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_kind_q != KindMove) |-> (m_char_q == '0))
    else $error("character field set on a non-move beat");
`endif

endmodule
